@@ hdl/vtg_pkg.sv @@
// vtg_pkg: shared types, tone table and constants of the vario tone generator
// used by every module of the block but vtg_div; depends on nothing

package vtg_pkg;

  localparam int TabSlots = 16;
  localparam int IdxW     = 4;

  localparam logic signed [15:0] TAB_MS [TabSlots] = '{
    -16'sd1000, -16'sd300, -16'sd200, -16'sd100, -16'sd50, 16'sd0, 16'sd50, 16'sd100,
    16'sd200, 16'sd300, 16'sd500, 16'sd1000, 16'sd0, 16'sd0, 16'sd0, 16'sd0};
  localparam logic signed [15:0] TAB_HZ [TabSlots] = '{
    16'sd288, 16'sd416, 16'sd448, 16'sd480, 16'sd496, 16'sd512, 16'sd550, 16'sd590,
    16'sd670, 16'sd704, 16'sd880, 16'sd1100, 16'sd0, 16'sd0, 16'sd0, 16'sd0};
  localparam logic signed [15:0] TAB_CYC [TabSlots] = '{
    16'sd650, 16'sd650, 16'sd650, 16'sd650, 16'sd650, 16'sd600, 16'sd600, 16'sd550,
    16'sd400, 16'sd310, 16'sd250, 16'sd200, 16'sd0, 16'sd0, 16'sd0, 16'sd0};
  localparam logic signed [15:0] TAB_DUTY [TabSlots] = '{
    16'sd80, 16'sd80, 16'sd80, 16'sd80, 16'sd80, 16'sd50, 16'sd50, 16'sd50,
    16'sd50, 16'sd50, 16'sd50, 16'sd50, 16'sd0, 16'sd0, 16'sd0, 16'sd0};

  localparam logic signed [31:0] PERIOD_NUM = 32'sd7812;
  localparam logic signed [31:0] BEEP_MUL   = 32'sd1000;

  // divide by 100 as multiply by ceil(2^26 / 100) and shift by 26
  localparam logic [19:0] PAUSE_RCP = 20'd671089;
  localparam int          PAUSE_SHR = 26;

  localparam logic CFG_SILENCE_LOW  = 1'b0;
  localparam logic CFG_SILENCE_HIGH = 1'b1;

  typedef enum logic [2:0] {
    OP_HZ    = 3'd0,
    OP_CYC   = 3'd1,
    OP_DUTY  = 3'd2,
    OP_PER   = 3'd3,
    OP_PAUSE = 3'd4
  } op_e;

  typedef struct packed {
    logic accept;
    logic setup;
    logic mul;
    logic div_start;
    logic store;
    logic commit;
    op_e  op;
  } vtg_cmd_t;

  typedef struct packed {
    logic sample_go;
    logic div_done;
  } vtg_sts_t;

endpackage

@@ hdl/vario_tone_generator_core.sv @@
// Vario tone generator: a tick item (mode 0) is taken and answered in the next
// cycle. A climb-rate sample (mode 1) is answered at once with the new
// playing flag; when it is not silenced the block then computes the beep
// parameters (a setup step, four rounds of a multiply, a divider start and
// a wait on the shared serial divider, a multiply and a reciprocal multiply
// for the pause, then a load-buffer commit) and accepts no item meanwhile.
// Configuration writes take effect at the clock edge. Each item yields
// exactly one result.
// depends on vtg_pkg, vtg_ctrl, vtg_dp

module vario_tone_generator_core
  import vtg_pkg::*;
#(
  parameter int TABLE_POINTS = 12
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic               cfg_addr_i,
  input  logic signed [15:0] cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               mode_i,
  input  logic signed [15:0] vertical_speed_i,
  input  logic               play_enable_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               buzzer_level_o,
  output logic               tone_active_o
);

  localparam int Npts = (TABLE_POINTS < 2) ? 2 :
                        (TABLE_POINTS > TabSlots) ? TabSlots : TABLE_POINTS;

  vtg_cmd_t cmd;
  vtg_sts_t sts;

  vtg_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .mode_i      (mode_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  vtg_dp #(.Npts(Npts)) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_addr_i       (cfg_addr_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .mode_i           (mode_i),
    .vertical_speed_i (vertical_speed_i),
    .play_enable_i    (play_enable_i),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .buzzer_level_o   (buzzer_level_o),
    .tone_active_o    (tone_active_o)
  );

endmodule

@@ hdl/vtg_div.sv @@
// vtg_div: signed divider, one quotient bit per cycle while busy, truncates toward zero
// depends on nothing but the clock and reset

module vtg_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [31:0] num_i,
  input  logic signed [31:0] den_i,
  output logic               done_o,
  output logic signed [31:0] quo_o
);

  logic [31:0] rem_q, quo_q, den_q;
  logic        neg_q, busy_q, done_q;
  logic [4:0]  cnt_q;
  logic [33:0] trial;

  assign trial = {1'b0, rem_q, quo_q[31]} - {2'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 5'd1;
        if (cnt_q == 5'd31) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= num_i[31] ? 32'(-num_i) : num_i;
      den_q <= den_i[31] ? 32'(-den_i) : den_i;
      neg_q <= num_i[31] ^ den_i[31];
    end else if (busy_q) begin
      rem_q <= trial[33] ? {rem_q[30:0], quo_q[31]} : trial[31:0];
      quo_q <= {quo_q[30:0], ~trial[33]};
    end
  end

  assign done_o = done_q;
  assign quo_o  = neg_q ? -$signed(quo_q) : $signed(quo_q);

endmodule

@@ hdl/vtg_ctrl.sv @@
// vtg_ctrl: sequencer for the sample computation and the result handshake
// depends on vtg_pkg

module vtg_ctrl
  import vtg_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  logic     mode_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  input  vtg_sts_t sts_i,
  output vtg_cmd_t cmd_o
);

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_SETUP  = 6'b000010,
    ST_MUL    = 6'b000100,
    ST_DIV    = 6'b001000,
    ST_WAIT   = 6'b010000,
    ST_COMMIT = 6'b100000
  } state_e;

  state_e state_q, state_d;
  op_e    op_q, op_d;
  logic   out_valid_q, out_valid_d;
  logic   accept;

  assign in_ready_o  = (state_q == ST_IDLE) && (!out_valid_q || out_ready_i);
  assign accept      = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) out_valid_d = 1'b0;
    if (accept) out_valid_d = 1'b1;
    cmd_o           = '0;
    cmd_o.accept    = accept;
    cmd_o.op        = op_q;
    case (state_q)
      ST_IDLE: begin
        if (accept && mode_i && sts_i.sample_go) state_d = ST_SETUP;
      end
      ST_SETUP: begin
        cmd_o.setup = 1'b1;
        op_d        = OP_HZ;
        state_d     = ST_MUL;
      end
      ST_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = ST_DIV;
      end
      ST_DIV: begin
        // pause uses the reciprocal multiply, not the divider
        if (op_q == OP_PAUSE) begin
          state_d = ST_COMMIT;
        end else begin
          cmd_o.div_start = 1'b1;
          state_d         = ST_WAIT;
        end
      end
      ST_WAIT: begin
        if (sts_i.div_done) begin
          cmd_o.store = 1'b1;
          case (op_q)
            OP_HZ:   op_d = OP_CYC;
            OP_CYC:  op_d = OP_DUTY;
            OP_DUTY: op_d = OP_PER;
            OP_PER:  op_d = OP_PAUSE;
            default: op_d = OP_PAUSE;
          endcase
          state_d = ST_MUL;
        end
      end
      ST_COMMIT: begin
        cmd_o.commit = 1'b1;
        state_d      = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      op_q        <= OP_HZ;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      op_q        <= op_d;
      out_valid_q <= out_valid_d;
    end
  end

`ifndef SYNTHESIS
  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> state_q == ST_IDLE) else $error("ready outside idle");
  a_go_setup: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && mode_i && sts_i.sample_go) |=> state_q == ST_SETUP)
    else $error("sample not started");
  a_wait_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WAIT && !sts_i.div_done) |=> state_q == ST_WAIT)
    else $error("left wait early");
  a_out_set: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> out_valid_q) else $error("item without result");
`endif

endmodule

@@ hdl/vtg_dp.sv @@
// vtg_dp: configuration, table interpolation, load and work buffers, square wave
// depends on vtg_pkg and vtg_div

module vtg_dp
  import vtg_pkg::*;
#(
  parameter int Npts = 12
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic               cfg_addr_i,
  input  logic signed [15:0] cfg_wdata_i,
  input  logic               mode_i,
  input  logic signed [15:0] vertical_speed_i,
  input  logic               play_enable_i,
  input  vtg_cmd_t           cmd_i,
  output vtg_sts_t           sts_o,
  output logic               buzzer_level_o,
  output logic               tone_active_o
);

  logic signed [15:0] sil_lo_q, sil_hi_q;
  logic               playing_q, buzzer_q;
  logic [15:0] ld_per_q, ld_half_q, ld_beep_q, ld_pause_q;
  logic [15:0] wk_per_q, wk_half_q, wk_left_q, wk_pause_q, wave_q;

  logic signed [15:0] v_q, x0_q, x1_q, hz0_q, hz1_q, cy0_q, cy1_q, du0_q, du1_q;
  logic               direct_q;
  logic signed [15:0] hz_q, cyc_q, duty_q, per_q;
  logic signed [31:0] left_q, prod_q;

  // setup: clamp and segment search
  logic signed [15:0] vc;
  logic [IdxW-1:0]    idx, prv;
  logic               found;

  always_comb begin
    vc = v_q;
    if (v_q < TAB_MS[0]) vc = TAB_MS[0];
    if (v_q > TAB_MS[Npts-1]) vc = TAB_MS[Npts-1];
    idx   = IdxW'(Npts - 1);
    found = 1'b0;
    for (int k = 0; k < TabSlots - 1; k++) begin
      if (k < Npts - 1 && !found && !(vc > TAB_MS[k])) begin
        idx   = IdxW'(k);
        found = 1'b1;
      end
    end
    prv = idx - IdxW'(1);
  end

  // operand selection
  logic signed [31:0] mul_a, div_num, div_den, quo, tmul;
  logic signed [16:0] mul_b, dx;
  logic signed [15:0] y0, y1, lerp_res;
  logic               div_done;

  assign dx = 17'(v_q) - 17'(x0_q);

  always_comb begin
    case (cmd_i.op)
      OP_HZ:   begin y0 = hz0_q; y1 = hz1_q; end
      OP_CYC:  begin y0 = cy0_q; y1 = cy1_q; end
      default: begin y0 = du0_q; y1 = du1_q; end
    endcase
    if (cmd_i.op == OP_PAUSE) begin
      mul_a = left_q;
      mul_b = 17'(duty_q);
    end else begin
      mul_a = 32'(dx);
      mul_b = 17'(y1) - 17'(y0);
    end
    case (cmd_i.op)
      OP_PER: begin
        div_num = PERIOD_NUM;
        div_den = 32'(hz_q);
      end
      default: begin
        div_num = prod_q;
        div_den = 32'(x1_q) - 32'(x0_q);
      end
    endcase
  end

  assign lerp_res = direct_q ? y1 : 16'(quo) + y0;
  assign tmul     = 32'(cyc_q) * BEEP_MUL;

  // pause share: product divided by 100, truncated toward zero
  logic [31:0]        pause_mag, pause_div;
  logic [51:0]        pause_rcp_q;
  logic signed [31:0] pause_quo;

  assign pause_mag = prod_q[31] ? 32'(-prod_q) : 32'(prod_q);
  assign pause_div = 32'(pause_rcp_q[51:PAUSE_SHR]);
  assign pause_quo = prod_q[31] ? -$signed(pause_div) : $signed(pause_div);

  vtg_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quo_o   (quo)
  );

  logic silenced;
  assign silenced = !play_enable_i ||
                    (vertical_speed_i > sil_lo_q && vertical_speed_i < sil_hi_q);

  assign sts_o.sample_go = !silenced;
  assign sts_o.div_done  = div_done;

  // tick
  logic        reload;
  logic [15:0] t_per, t_half, t_left, t_pause, wave_d;
  logic        buzz_d;

  always_comb begin
    reload  = (wk_left_q == 16'd0) && playing_q;
    t_per   = reload ? ld_per_q : wk_per_q;
    t_half  = reload ? ld_half_q : wk_half_q;
    t_left  = reload ? ld_beep_q : wk_left_q;
    t_pause = reload ? ld_pause_q : wk_pause_q;
    wave_d  = wave_q;
    buzz_d  = buzzer_q;
    if (t_left > t_pause) begin
      if (wave_q == t_half) begin
        buzz_d = 1'b0;
        wave_d = wave_q + 16'd1;
      end else if (wave_q >= t_per) begin
        buzz_d = 1'b1;
        wave_d = 16'd1;
      end else begin
        wave_d = wave_q + 16'd1;
      end
    end else begin
      buzz_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sil_lo_q   <= -16'sd60;
      sil_hi_q   <= 16'sd10;
      playing_q  <= 1'b0;
      buzzer_q   <= 1'b0;
      ld_per_q   <= '0;
      ld_half_q  <= '0;
      ld_beep_q  <= '0;
      ld_pause_q <= '0;
      wk_per_q   <= '0;
      wk_half_q  <= '0;
      wk_left_q  <= '0;
      wk_pause_q <= '0;
      wave_q     <= '0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_addr_i == CFG_SILENCE_LOW) sil_lo_q <= cfg_wdata_i;
        else sil_hi_q <= cfg_wdata_i;
      end
      if (cmd_i.accept) begin
        if (mode_i) begin
          playing_q <= !silenced;
        end else begin
          wk_per_q   <= t_per;
          wk_half_q  <= t_half;
          wk_pause_q <= t_pause;
          wk_left_q  <= (t_left != 16'd0) ? t_left - 16'd1 : 16'd0;
          wave_q     <= wave_d;
          buzzer_q   <= buzz_d;
        end
      end
      if (cmd_i.commit) begin
        ld_per_q   <= per_q;
        ld_half_q  <= {1'b0, per_q[15:1]};
        ld_beep_q  <= left_q[15:0];
        ld_pause_q <= 16'(left_q - pause_quo);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept && mode_i) v_q <= vertical_speed_i;
    if (cmd_i.setup) begin
      v_q      <= vc;
      x0_q     <= TAB_MS[prv];
      x1_q     <= TAB_MS[idx];
      hz0_q    <= TAB_HZ[prv];
      hz1_q    <= TAB_HZ[idx];
      cy0_q    <= TAB_CYC[prv];
      cy1_q    <= TAB_CYC[idx];
      du0_q    <= TAB_DUTY[prv];
      du1_q    <= TAB_DUTY[idx];
      direct_q <= (vc == TAB_MS[idx]) || (idx == '0) || (TAB_MS[idx] == TAB_MS[prv]);
    end
    if (cmd_i.mul) prod_q <= 32'(mul_a * 32'(mul_b));
    pause_rcp_q <= pause_mag * PAUSE_RCP;
    if (cmd_i.store) begin
      case (cmd_i.op)
        OP_HZ:   hz_q   <= lerp_res;
        OP_CYC:  cyc_q  <= lerp_res;
        OP_DUTY: begin
          duty_q <= lerp_res;
          left_q <= (tmul + (tmul[31] ? 32'sd127 : 32'sd0)) >>> 7;
        end
        OP_PER:  per_q  <= (hz_q > 16'sd0) ? quo[15:0] : 16'd0;
        default: ;
      endcase
    end
  end

  assign buzzer_level_o = buzzer_q;
  assign tone_active_o  = playing_q;

endmodule
